[sv/uvs_pkg.sv]
// Package for the UV sphere vertex generator: widths, register indexes,
// pipeline lengths, the CORDIC angle table and the shared struct types.
// Depends on nothing; every other file of the block imports it.
package uvs_pkg;

    // Field widths
    localparam int CNT_W     = 10;
    localparam int IDX_W     = 20;
    localparam int RAD_W     = 16;
    localparam int POS_W     = 17;
    localparam int NORM_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RINGS     = 2'd2;

    // Register reset values
    localparam logic [RAD_W-1:0] RADIUS_RESET   = 16'd256;
    localparam logic [CNT_W-1:0] SEGMENTS_RESET = 10'd36;
    localparam logic [CNT_W-1:0] RINGS_RESET    = 10'd18;

    localparam logic [CNT_W-1:0] MAX_DIVISIONS = 10'd1023;

    // Pipeline lengths
    localparam int DIV_STEPS    = 32;
    localparam int DIV_LAT      = DIV_STEPS;
    localparam int CORDIC_STEPS = 30;
    localparam int COR_LAT      = CORDIC_STEPS + 2;
    localparam int SIDE_LAT     = DIV_LAT + COR_LAT + 3;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // CORDIC start vector, Q2.30 with the gain compensated
    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

    localparam logic signed [POS_W+2:0]  POS_LIMIT  = 20'sd65535;
    localparam logic signed [NORM_W+1:0] NORM_LIMIT = 18'sd32767;

    // Per-item data that bypasses the arithmetic
    typedef struct packed {
        logic             oor;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
        logic             upper;
        logic             lower;
    } side_t;

    // A classified request as it enters the queue
    typedef struct packed {
        side_t            side;
        logic [CNT_W-1:0] az_rinit;
        logic [31:0]      az_low;
        logic [CNT_W-1:0] el_rinit;
        logic [31:0]      el_low;
    } front_t;

    // Effective configuration seen by the back end
    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [CNT_W-1:0] segs;
        logic [CNT_W-1:0] rings;
    } geom_t;

    // Rotation angles in units of 2^-32 turn
    function automatic logic signed [32:0] cordic_atan(input int unsigned i);
        case (i)
            0:       return 33'sd536870912;
            1:       return 33'sd316933406;
            2:       return 33'sd167458907;
            3:       return 33'sd85004756;
            4:       return 33'sd42667331;
            5:       return 33'sd21354465;
            6:       return 33'sd10679838;
            7:       return 33'sd5340245;
            8:       return 33'sd2670163;
            9:       return 33'sd1335087;
            10:      return 33'sd667544;
            11:      return 33'sd333772;
            12:      return 33'sd166886;
            13:      return 33'sd83443;
            14:      return 33'sd41722;
            15:      return 33'sd20861;
            16:      return 33'sd10430;
            17:      return 33'sd5215;
            18:      return 33'sd2608;
            19:      return 33'sd1304;
            20:      return 33'sd652;
            21:      return 33'sd326;
            22:      return 33'sd163;
            23:      return 33'sd81;
            24:      return 33'sd41;
            25:      return 33'sd20;
            26:      return 33'sd10;
            27:      return 33'sd5;
            28:      return 33'sd3;
            29:      return 33'sd1;
            default: return 33'sd0;
        endcase
    endfunction

endpackage

[sv/uvs_if.sv]
// Handshake channels of the UV sphere vertex generator: grid point
// requests, vertex results and configuration writes. Depends on uvs_pkg.

interface uvs_item_if;
    import uvs_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] ring_index;
    logic [CNT_W-1:0] segment_index;
    modport source (output valid, ring_index, segment_index, input ready);
    modport sink   (input valid, ring_index, segment_index, output ready);
endinterface

interface uvs_result_if;
    import uvs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [IDX_W-1:0]         base_upper;
    logic [IDX_W-1:0]         base_lower;
    logic                     upper_tri_valid;
    logic                     lower_tri_valid;
    logic                     out_of_range;
    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    base_upper, base_lower, upper_tri_valid, lower_tri_valid,
                    out_of_range, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    base_upper, base_lower, upper_tri_valid, lower_tri_valid,
                    out_of_range, output ready);
endinterface

interface uvs_cfg_if;
    import uvs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/uvs_front.sv]
// Front end: configuration registers, request acceptance and classification
// (range check, cell indexes, divider operands). Depends on uvs_pkg, uvs_if.

module uvs_front (
    input  logic            clk,
    input  logic            rst_n,
    uvs_item_if.sink        item,
    uvs_cfg_if.sink         cfg,
    input  logic            fifo_full,
    output logic            push,
    output uvs_pkg::front_t push_data,
    output uvs_pkg::geom_t  geom
);
    import uvs_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    logic [CNT_W-1:0] seg_cnt_reg;
    logic [CNT_W-1:0] ring_cnt_reg;
    logic             fv_reg;
    front_t           fdata_reg;
    front_t           fdata_next;
    logic [CNT_W-1:0] segs;
    logic [CNT_W-1:0] rings;
    logic [CNT_W:0]   segs1;
    logic [IDX_W:0]   k1_full;
    logic             in_fire;
    logic             in_cell;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RADIUS_RESET;
            seg_cnt_reg  <= SEGMENTS_RESET;
            ring_cnt_reg <= RINGS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RADIUS:   radius_reg   <= cfg.data;
                CFG_SEGMENTS: seg_cnt_reg  <= cfg.data[CNT_W-1:0];
                CFG_RINGS:    ring_cnt_reg <= cfg.data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Zero counts act as one, counts above the limit act as the limit.
    always_comb
    begin
        segs  = (seg_cnt_reg == '0) ? CNT_W'(1) :
                (seg_cnt_reg > MAX_DIVISIONS) ? MAX_DIVISIONS : seg_cnt_reg;
        rings = (ring_cnt_reg == '0) ? CNT_W'(1) :
                (ring_cnt_reg > MAX_DIVISIONS) ? MAX_DIVISIONS : ring_cnt_reg;
    end

    assign geom = '{radius: radius_reg, segs: segs, rings: rings};

    // Classify the incoming grid point.
    always_comb
    begin
        segs1   = {1'b0, segs} + (CNT_W+1)'(1);
        k1_full = (IDX_W+1)'(item.ring_index) * (IDX_W+1)'(segs1)
                + (IDX_W+1)'(item.segment_index);
        in_cell = (item.ring_index < rings) && (item.segment_index < segs);

        fdata_next.side.oor   = (item.ring_index > rings) || (item.segment_index > segs);
        fdata_next.side.k1    = in_cell ? k1_full[IDX_W-1:0] : '0;
        fdata_next.side.k2    = in_cell ? k1_full[IDX_W-1:0] + IDX_W'(segs1) : '0;
        fdata_next.side.upper = in_cell && (item.ring_index != '0);
        fdata_next.side.lower = in_cell && (item.ring_index != rings - CNT_W'(1));

        // Azimuth numerator segment*2^32 + segs/2, top quotient bit dropped.
        fdata_next.az_rinit = (item.segment_index == segs) ? '0 : item.segment_index;
        fdata_next.az_low   = {23'b0, segs[CNT_W-1:1]};
        // Elevation numerator ring*2^31 + rings/2.
        fdata_next.el_rinit = {1'b0, item.ring_index[CNT_W-1:1]};
        fdata_next.el_low   = {item.ring_index[0], 22'b0, rings[CNT_W-1:1]};
    end

    assign item.ready = !fv_reg || !fifo_full;
    assign in_fire    = item.valid && item.ready;
    assign push       = fv_reg && !fifo_full;
    assign push_data  = fdata_reg;

    // Holding register ahead of the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            fv_reg <= 1'b1;
        end
        else if (push)
        begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fdata_reg <= fdata_next;
        end
    end

endmodule

[sv/uvs_fifo.sv]
// Short request queue between the front and the back end.
// Depends on uvs_pkg.

module uvs_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  uvs_pkg::front_t push_data,
    output logic            full,
    input  logic            pop,
    output uvs_pkg::front_t pop_data,
    output logic            not_empty
);
    import uvs_pkg::*;

    front_t             mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

[sv/uvs_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for the angle
// phases. The dividend is rinit*2^32 + low with rinit below the divisor.
// Depends on uvs_pkg.

module uvs_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [uvs_pkg::CNT_W-1:0] rinit,
    input  logic [31:0]               low,
    input  logic [uvs_pkg::CNT_W-1:0] divisor,
    output logic [31:0]               quo
);
    import uvs_pkg::*;

    logic [CNT_W-1:0] rem_in  [0:DIV_STEPS-1];
    logic [31:0]      num_in  [0:DIV_STEPS-1];
    logic [31:0]      quo_in  [0:DIV_STEPS-1];
    logic [CNT_W-1:0] rem_reg [1:DIV_STEPS];
    logic [31:0]      num_reg [1:DIV_STEPS];
    logic [31:0]      quo_reg [1:DIV_STEPS];

    assign rem_in[0] = rinit;
    assign num_in[0] = low;
    assign quo_in[0] = '0;
    assign quo       = quo_reg[DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic [CNT_W:0]   trial;
        logic             ge;
        logic [CNT_W:0]   diff;

        if (s > 0)
        begin : g_link
            assign rem_in[s] = rem_reg[s];
            assign num_in[s] = num_reg[s];
            assign quo_in[s] = quo_reg[s];
        end

        // Shift in the next dividend bit and try a subtraction.
        assign trial = {rem_in[s], num_in[s][31]};
        assign ge    = (trial >= {1'b0, divisor});
        assign diff  = trial - {1'b0, divisor};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                num_reg[s+1] <= {num_in[s][30:0], 1'b0};
                quo_reg[s+1] <= {quo_in[s][30:0], ge};
            end
        end
    end

endmodule

[sv/uvs_cordic.sv]
// Pipelined rotation-mode CORDIC giving cosine and sine in Q2.30 of a
// 32-bit phase, with half-turn folding of the middle quadrants.
// Depends on uvs_pkg.

module uvs_cordic (
    input  logic                    clk,
    input  logic                    en,
    input  logic [31:0]             phase,
    output logic signed [32:0]      cos_o,
    output logic signed [32:0]      sin_o
);
    import uvs_pkg::*;

    logic signed [32:0] x_reg [0:CORDIC_STEPS];
    logic signed [32:0] y_reg [0:CORDIC_STEPS];
    logic signed [32:0] z_reg [0:CORDIC_STEPS];
    logic               flip_reg [0:CORDIC_STEPS];
    logic signed [32:0] cos_reg;
    logic signed [32:0] sin_reg;
    logic               flip;
    logic [31:0]        folded;

    // Fold the second and third quadrants by half a turn.
    assign flip   = phase[31] ^ phase[30];
    assign folded = flip ? {~phase[31], phase[30:0]} : phase;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_START;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({folded[31], folded});
            flip_reg[0] <= flip;
        end
    end

    // Micro-rotations
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][32])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - cordic_atan(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + cordic_atan(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // Undo the fold.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end

    assign cos_o = cos_reg;
    assign sin_o = sin_reg;

endmodule

[sv/uvs_back.sv]
// Back end: angle division, CORDIC, unit products, scaling by the radius,
// rounding, saturation and the result register. Depends on uvs_pkg, uvs_if,
// uvs_div and uvs_cordic.

module uvs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            not_empty,
    input  uvs_pkg::front_t pop_data,
    input  uvs_pkg::geom_t  geom,
    output logic            pop,
    uvs_result_if.source    result
);
    import uvs_pkg::*;

    localparam logic signed [65:0] PROD_HALF = 66'sd536870912;
    localparam logic signed [49:0] MUL_HALF  = 50'sd536870912;
    localparam logic signed [32:0] NORM_HALF = 33'sd16384;

    logic               en;
    logic               valid_reg [0:SIDE_LAT-1];
    side_t              side_reg  [0:SIDE_LAT-1];
    logic [31:0]        q_az;
    logic [31:0]        q_el;
    logic [31:0]        el_phase;
    logic signed [32:0] ce, se, ca, sa;
    logic signed [65:0] pxy_reg [0:1];
    logic signed [32:0] pz_reg;
    logic signed [32:0] n_reg [0:2];
    logic signed [49:0] mul_reg [0:2];
    logic signed [NORM_W-1:0] nrm_reg [0:2];
    logic signed [NORM_W-1:0] nrm_next [0:2];
    logic signed [32:0] n_next [0:1];
    logic signed [POS_W-1:0] pos_next [0:2];

    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  pos_reg [0:2];
    logic signed [NORM_W-1:0] norm_out_reg [0:2];
    side_t                    side_out_reg;

    // The whole pipeline advances unless a finished result is held.
    assign en  = !out_valid_reg || result.ready;
    assign pop = en && not_empty;

    uvs_div u_div_az (
        .clk     (clk),
        .en      (en),
        .rinit   (pop_data.az_rinit),
        .low     (pop_data.az_low),
        .divisor (geom.segs),
        .quo     (q_az)
    );

    uvs_div u_div_el (
        .clk     (clk),
        .en      (en),
        .rinit   (pop_data.el_rinit),
        .low     (pop_data.el_low),
        .divisor (geom.rings),
        .quo     (q_el)
    );

    // Elevation is a quarter turn minus the ring angle.
    assign el_phase = 32'h4000_0000 - q_el;

    uvs_cordic u_cordic_el (
        .clk   (clk),
        .en    (en),
        .phase (el_phase),
        .cos_o (ce),
        .sin_o (se)
    );

    uvs_cordic u_cordic_az (
        .clk   (clk),
        .en    (en),
        .phase (q_az),
        .cos_o (ca),
        .sin_o (sa)
    );

    // Side data and valid bits travel alongside the arithmetic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= not_empty;
            for (int i = 1; i < SIDE_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= pop_data.side;
            for (int i = 1; i < SIDE_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Unit vector products and their rounding.
    always_comb
    begin
        n_next[0] = 33'((pxy_reg[0] + PROD_HALF) >>> 30);
        n_next[1] = 33'((pxy_reg[1] + PROD_HALF) >>> 30);
    end

    // Normal rounding and saturation.
    always_comb
    begin
        logic signed [NORM_W+1:0] ns;
        for (int j = 0; j < 3; j++)
        begin
            ns = (NORM_W+2)'((n_reg[j] + NORM_HALF) >>> 15);
            if (ns > NORM_LIMIT)
            begin
                nrm_next[j] = NORM_W'(NORM_LIMIT);
            end
            else if (ns < -NORM_LIMIT)
            begin
                nrm_next[j] = NORM_W'(-NORM_LIMIT);
            end
            else
            begin
                nrm_next[j] = ns[NORM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxy_reg[0] <= ce * ca;
            pxy_reg[1] <= ce * sa;
            pz_reg     <= se;
            n_reg[0]   <= n_next[0];
            n_reg[1]   <= n_next[1];
            n_reg[2]   <= pz_reg;
            for (int j = 0; j < 3; j++)
            begin
                mul_reg[j] <= $signed({1'b0, geom.radius}) * n_reg[j];
                nrm_reg[j] <= nrm_next[j];
            end
        end
    end

    // Position rounding and saturation.
    always_comb
    begin
        logic signed [POS_W+2:0] ps;
        for (int j = 0; j < 3; j++)
        begin
            ps = (POS_W+3)'((mul_reg[j] + MUL_HALF) >>> 30);
            if (ps > POS_LIMIT)
            begin
                pos_next[j] = POS_W'(POS_LIMIT);
            end
            else if (ps < -POS_LIMIT)
            begin
                pos_next[j] = POS_W'(-POS_LIMIT);
            end
            else
            begin
                pos_next[j] = ps[POS_W-1:0];
            end
        end
    end

    // Result register; a point outside the grid gives zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[SIDE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out_reg <= side_reg[SIDE_LAT-1];
            for (int j = 0; j < 3; j++)
            begin
                pos_reg[j]      <= side_reg[SIDE_LAT-1].oor ? '0 : pos_next[j];
                norm_out_reg[j] <= side_reg[SIDE_LAT-1].oor ? '0 : nrm_reg[j];
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.pos_x           = pos_reg[0];
    assign result.pos_y           = pos_reg[1];
    assign result.pos_z           = pos_reg[2];
    assign result.norm_x          = norm_out_reg[0];
    assign result.norm_y          = norm_out_reg[1];
    assign result.norm_z          = norm_out_reg[2];
    assign result.base_upper      = side_out_reg.k1;
    assign result.base_lower      = side_out_reg.k2;
    assign result.upper_tri_valid = side_out_reg.upper;
    assign result.lower_tri_valid = side_out_reg.lower;
    assign result.out_of_range    = side_out_reg.oor;

endmodule

[sv/uv_sphere_vertex_generator_unit.sv]
// UV sphere vertex generator, top level. From request acceptance to result
// valid a request passes the holding register, the queue, 32 divider stages,
// 32 CORDIC stages, three product and scaling stages and the result register.
// Throughput is one request per cycle; a held result stalls the back end,
// and the four-entry queue lets the front keep accepting meanwhile.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// radius, segment and ring registers with 1.0, 36 and 18.

module uv_sphere_vertex_generator_unit (
    input  logic         clk,
    input  logic         rst_n,
    uvs_item_if.sink     item,
    uvs_cfg_if.sink      cfg,
    uvs_result_if.source result
);
    import uvs_pkg::*;

    logic   push;
    logic   pop;
    logic   fifo_full;
    logic   not_empty;
    front_t push_data;
    front_t pop_data;
    geom_t  geom;

    uvs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data),
        .geom      (geom)
    );

    uvs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    uvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_data  (pop_data),
        .geom      (geom),
        .pop       (pop),
        .result    (result)
    );

endmodule

[sv/uvs_checker.sv]
// Port-level checks for the UV sphere vertex generator and the bind that
// attaches them to the top level. Depends on uvs_pkg.

module uvs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              valid,
    input logic                              ready,
    input logic signed [uvs_pkg::POS_W-1:0]  pos_x,
    input logic signed [uvs_pkg::POS_W-1:0]  pos_y,
    input logic signed [uvs_pkg::POS_W-1:0]  pos_z,
    input logic signed [uvs_pkg::NORM_W-1:0] norm_x,
    input logic signed [uvs_pkg::NORM_W-1:0] norm_y,
    input logic signed [uvs_pkg::NORM_W-1:0] norm_z,
    input logic [uvs_pkg::IDX_W-1:0]         base_upper,
    input logic                              upper_tri_valid,
    input logic                              lower_tri_valid,
    input logic                              out_of_range
);
    import uvs_pkg::*;

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result withdrawn while stalled");

    // A point outside the grid gives zero geometry and no triangles.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && out_of_range |-> pos_x == '0 && pos_y == '0 && pos_z == '0 &&
            norm_x == '0 && norm_y == '0 && norm_z == '0 && base_upper == '0 &&
            !upper_tri_valid && !lower_tri_valid)
        else $error("out-of-range result carries data");

    // Normals are saturated symmetrically.
    a_norm_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> norm_x != -16'sd32768 && norm_y != -16'sd32768 &&
            norm_z != -16'sd32768)
        else $error("normal outside saturation range");

    // Positions are saturated symmetrically.
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> pos_x != -17'sd65536 && pos_y != -17'sd65536 &&
            pos_z != -17'sd65536)
        else $error("position outside saturation range");

endmodule

bind uv_sphere_vertex_generator_unit uvs_checker u_uvs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (result.valid),
    .ready           (result.ready),
    .pos_x           (result.pos_x),
    .pos_y           (result.pos_y),
    .pos_z           (result.pos_z),
    .norm_x          (result.norm_x),
    .norm_y          (result.norm_y),
    .norm_z          (result.norm_z),
    .base_upper      (result.base_upper),
    .upper_tri_valid (result.upper_tri_valid),
    .lower_tri_valid (result.lower_tri_valid),
    .out_of_range    (result.out_of_range)
);
